### rtl/ubsb_pkg.sv
// Package for the uniform B-spline basis evaluator.
// Holds widths, fixed-point constants, register codes and the structs passed
// between the front end, the basis triangle and the result serializer.
package ubsb_pkg;

	localparam int MAX_KNOTS  = 64;
	localparam int MAX_DEGREE = 3;
	localparam int FRAC_BITS  = 16;

	localparam int SAMPLE_W  = 32;
	localparam int DEG_W     = 2;
	localparam int KNOT_W    = 7;
	localparam int IDX_W     = 7;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int WGT_W     = FRAC_BITS + 2;
	localparam int PROD_W    = WGT_W + VAL_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int N2_W      = SUM_W - FRAC_BITS;
	localparam int RECIP3_W  = 20;
	localparam int RECIP3_SH = 21;
	localparam int Q_W       = N2_W + RECIP3_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT  = 2'd3;

	// Fixed-point one in value and weight widths, plus small multiples.
	localparam logic [VAL_W-1:0] V_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [WGT_W-1:0] W_ONE   = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic [WGT_W-1:0] W_TWO   = {2'b10, {FRAC_BITS{1'b0}}};
	localparam logic [WGT_W-1:0] W_THREE = {2'b11, {FRAC_BITS{1'b0}}};

	// Rounding offsets: half of the level-2 and level-3 denominators.
	localparam logic [SUM_W-1:0] RND2 = SUM_W'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0] RND3 = SUM_W'(3) << (FRAC_BITS - 1);

	// ceil(2^21 / 3): floor(n * RECIP3 >> 21) equals n / 3 for n below 2^21.
	localparam logic [RECIP3_W-1:0] RECIP3 = 20'd699051;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [WGT_W-1:0]  wgt_t;
	typedef logic [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] grid_start;
		logic [SAMPLE_W-1:0]        inv_spacing;
		logic [DEG_W-1:0]           degree;
		logic [KNOT_W-1:0]          knot_count;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]     interval;
		logic [FRAC_BITS-1:0] u;
		logic                 oor;
	} loc_t;

	typedef struct packed {
		logic [IDX_W-1:0]            interval;
		logic                        oor;
		logic [MAX_DEGREE:0][VAL_W-1:0] val;
	} basis_t;

endpackage

### rtl/ubsb_front.sv
// Front end of the basis evaluator: grid offset, scaling by the inverse
// spacing and interval clamping, in three register stages. Uses ubsb_pkg.
module ubsb_front import ubsb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output loc_t                loc
);

	logic                v_s1, v_s2, v_s3;
	logic                en1, en2, en3;
	logic                neg_s1, neg_s2;
	logic [SAMPLE_W-1:0] d_s1;
	logic [47:0]         ph_s2, pl_s2;
	loc_t                loc_s3;

	logic [SAMPLE_W:0]   diff;
	logic [48:0]         tq;
	logic [32:0]         ival;
	logic [KNOT_W-1:0]   kc;
	loc_t                loc_next;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign diff = {sample[SAMPLE_W-1], sample} - {cfg.grid_start[SAMPLE_W-1], cfg.grid_start};

	// tq is floor(d * inv_spacing / 2^16), split over two 32x16 products.
	assign tq   = {1'b0, ph_s2} + {17'b0, pl_s2[47:16]};
	assign ival = tq[48:16];

	always_comb begin
		if (cfg.knot_count < KNOT_W'(2)) begin
			kc = KNOT_W'(2);
		end else if (cfg.knot_count > KNOT_W'(MAX_KNOTS)) begin
			kc = KNOT_W'(MAX_KNOTS);
		end else begin
			kc = cfg.knot_count;
		end
	end

	always_comb begin
		priority if (neg_s2) begin
			loc_next.interval = '0;
			loc_next.u        = '0;
			loc_next.oor      = 1'b1;
		end else if (ival >= {26'b0, kc - KNOT_W'(1)}) begin
			loc_next.interval = IDX_W'(kc - KNOT_W'(2));
			loc_next.u        = '1;
			loc_next.oor      = 1'b1;
		end else begin
			loc_next.interval = ival[IDX_W-1:0];
			loc_next.u        = tq[FRAC_BITS-1:0];
			loc_next.oor      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			neg_s1 <= diff[SAMPLE_W];
			d_s1   <= diff[SAMPLE_W-1:0];
		end
		if (en2) begin
			neg_s2 <= neg_s1;
			ph_s2  <= 48'(d_s1) * 48'(cfg.inv_spacing[31:16]);
			pl_s2  <= 48'(d_s1) * 48'(cfg.inv_spacing[15:0]);
		end
		if (en3) begin
			loc_s3 <= loc_next;
		end
	end

	assign out_valid = v_s3;
	assign loc       = loc_s3;

endmodule

### rtl/ubsb_tri.sv
// Cox-de Boor triangle for unit knot spacing, five register stages:
// level one, then products and rounding for levels two and three. Uses ubsb_pkg.
module ubsb_tri import ubsb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DEG_W-1:0] degree,
	input  logic             in_valid,
	output logic             in_ready,
	input  loc_t             loc,
	output logic             out_valid,
	input  logic             out_ready,
	output basis_t           basis
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [IDX_W-1:0] iv_s1, iv_s2, iv_s3, iv_s4, iv_s5;
	logic             oor_s1, oor_s2, oor_s3, oor_s4, oor_s5;
	wgt_t             uw_s1, uw_s2, uw_s3;

	val_t  v0_s1, v1_s1;
	val_t  v0_s2, v1_s2;
	prod_t p0_s2, p1l_s2, p1r_s2, p2_s2;
	val_t  v0_s3, v1_s3, v2_s3;
	val_t  v0_s4, v1_s4, v2_s4;
	prod_t p0_s4, p1l_s4, p1r_s4, p2l_s4, p2r_s4, p3_s4;
	val_t  v0_s5, v1_s5, v2_s5;
	logic [Q_W-1:0] q0_s5, q1_s5, q2_s5, q3_s5;

	wgt_t             uw_in;
	logic [SUM_W-1:0] s2_0, s2_1, s2_2;
	logic [SUM_W-1:0] s3_0, s3_1, s3_2, s3_3;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign uw_in = {2'b00, loc.u};

	// Level two sums, rounded half up before the divide by two.
	assign s2_0 = SUM_W'(p0_s2) + RND2;
	assign s2_1 = SUM_W'(p1l_s2) + SUM_W'(p1r_s2) + RND2;
	assign s2_2 = SUM_W'(p2_s2) + RND2;

	// Level three sums; the divide by three continues through the reciprocal.
	assign s3_0 = SUM_W'(p0_s4) + RND3;
	assign s3_1 = SUM_W'(p1l_s4) + SUM_W'(p1r_s4) + RND3;
	assign s3_2 = SUM_W'(p2l_s4) + SUM_W'(p2r_s4) + RND3;
	assign s3_3 = SUM_W'(p3_s4) + RND3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			iv_s1  <= loc.interval;
			oor_s1 <= loc.oor;
			uw_s1  <= uw_in;
			// Level one with unit spacing is exact: one minus u and u.
			if (degree >= DEG_W'(1)) begin
				v0_s1 <= V_ONE - {1'b0, loc.u};
				v1_s1 <= {1'b0, loc.u};
			end else begin
				v0_s1 <= V_ONE;
				v1_s1 <= '0;
			end
		end
		if (en2) begin
			iv_s2  <= iv_s1;
			oor_s2 <= oor_s1;
			uw_s2  <= uw_s1;
			v0_s2  <= v0_s1;
			v1_s2  <= v1_s1;
			p0_s2  <= PROD_W'(W_ONE - uw_s1) * PROD_W'(v0_s1);
			p1l_s2 <= PROD_W'(uw_s1 + W_ONE) * PROD_W'(v0_s1);
			p1r_s2 <= PROD_W'(W_TWO - uw_s1) * PROD_W'(v1_s1);
			p2_s2  <= PROD_W'(uw_s1) * PROD_W'(v1_s1);
		end
		if (en3) begin
			iv_s3  <= iv_s2;
			oor_s3 <= oor_s2;
			uw_s3  <= uw_s2;
			if (degree >= DEG_W'(2)) begin
				v0_s3 <= s2_0[FRAC_BITS+1 +: VAL_W];
				v1_s3 <= s2_1[FRAC_BITS+1 +: VAL_W];
				v2_s3 <= s2_2[FRAC_BITS+1 +: VAL_W];
			end else begin
				v0_s3 <= v0_s2;
				v1_s3 <= v1_s2;
				v2_s3 <= '0;
			end
		end
		if (en4) begin
			iv_s4  <= iv_s3;
			oor_s4 <= oor_s3;
			v0_s4  <= v0_s3;
			v1_s4  <= v1_s3;
			v2_s4  <= v2_s3;
			p0_s4  <= PROD_W'(W_ONE - uw_s3) * PROD_W'(v0_s3);
			p1l_s4 <= PROD_W'(uw_s3 + W_TWO) * PROD_W'(v0_s3);
			p1r_s4 <= PROD_W'(W_TWO - uw_s3) * PROD_W'(v1_s3);
			p2l_s4 <= PROD_W'(uw_s3 + W_ONE) * PROD_W'(v1_s3);
			p2r_s4 <= PROD_W'(W_THREE - uw_s3) * PROD_W'(v2_s3);
			p3_s4  <= PROD_W'(uw_s3) * PROD_W'(v2_s3);
		end
		if (en5) begin
			iv_s5  <= iv_s4;
			oor_s5 <= oor_s4;
			v0_s5  <= v0_s4;
			v1_s5  <= v1_s4;
			v2_s5  <= v2_s4;
			q0_s5  <= Q_W'(s3_0[SUM_W-1:FRAC_BITS]) * Q_W'(RECIP3);
			q1_s5  <= Q_W'(s3_1[SUM_W-1:FRAC_BITS]) * Q_W'(RECIP3);
			q2_s5  <= Q_W'(s3_2[SUM_W-1:FRAC_BITS]) * Q_W'(RECIP3);
			q3_s5  <= Q_W'(s3_3[SUM_W-1:FRAC_BITS]) * Q_W'(RECIP3);
		end
	end

	always_comb begin
		basis.interval = iv_s5;
		basis.oor      = oor_s5;
		if (degree == DEG_W'(3)) begin
			basis.val[0] = q0_s5[RECIP3_SH +: VAL_W];
			basis.val[1] = q1_s5[RECIP3_SH +: VAL_W];
			basis.val[2] = q2_s5[RECIP3_SH +: VAL_W];
			basis.val[3] = q3_s5[RECIP3_SH +: VAL_W];
		end else begin
			basis.val[0] = v0_s5;
			basis.val[1] = v1_s5;
			basis.val[2] = v2_s5;
			basis.val[3] = '0;
		end
	end

	assign out_valid = v_s5;

endmodule

### rtl/ubsb_ser.sv
// Result serializer: holds one sample's basis values and sends them one
// beat per cycle while out_ready is high, in order of rising basis index. Uses ubsb_pkg.
module ubsb_ser import ubsb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DEG_W-1:0] degree,
	input  logic             in_valid,
	output logic             in_ready,
	input  basis_t           basis,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] out_index,
	output logic [VAL_W-1:0] out_value,
	output logic             out_last,
	output logic             out_oor
);

	logic                         busy_q;
	logic [DEG_W-1:0]             cnt_q;
	logic [DEG_W-1:0]             deg_q;
	logic [IDX_W-1:0]             interval_q;
	logic                         oor_q;
	logic [MAX_DEGREE:0][VAL_W-1:0] val_q;

	assign out_last  = cnt_q == deg_q;
	// The next sample loads as the final beat of this one leaves.
	assign in_ready  = !busy_q || (out_ready && out_last);
	assign out_valid = busy_q;
	assign out_index = interval_q + IDX_W'(cnt_q);
	assign out_value = val_q[cnt_q];
	assign out_oor   = oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			cnt_q  <= '0;
		end else if (out_ready) begin
			cnt_q <= cnt_q + DEG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			deg_q      <= degree;
			interval_q <= basis.interval;
			oor_q      <= basis.oor;
			val_q      <= basis.val;
		end
	end

endmodule

### rtl/uniform_bspline_basis_eval.sv
// Uniform B-spline basis evaluator, top level. Uses ubsb_pkg and the
// submodules ubsb_front, ubsb_tri and ubsb_ser.
// Throughput is set by the result port, which sends degree+1 beats per sample, one per cycle while m_tready is high;
// a new sample is taken every cycle while the eight pipeline stages have room.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module uniform_bspline_basis_eval import ubsb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [6:0] basis_index, [23:7] basis_value
	output logic                  m_tlast,
	output logic [0:0]            m_tuser    // [0] out_of_range
);

	cfg_t             cfg_q;
	logic             loc_valid, loc_ready;
	loc_t             loc;
	logic             bas_valid, bas_ready;
	basis_t           bas;
	logic [IDX_W-1:0] out_index;
	logic [VAL_W-1:0] out_value;
	logic             out_oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_start  <= '0;
			cfg_q.inv_spacing <= 32'd65536;
			cfg_q.degree      <= DEG_W'(3);
			cfg_q.knot_count  <= KNOT_W'(20);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_START:  cfg_q.grid_start  <= cfg_wdata;
				CFG_INV_SPACING: cfg_q.inv_spacing <= cfg_wdata;
				CFG_DEGREE:      cfg_q.degree      <= cfg_wdata[DEG_W-1:0];
				CFG_KNOT_COUNT:  cfg_q.knot_count  <= cfg_wdata[KNOT_W-1:0];
			endcase
		end
	end

	ubsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (s_tdata),
		.out_valid (loc_valid),
		.out_ready (loc_ready),
		.loc       (loc)
	);

	ubsb_tri u_tri (
		.clk       (clk),
		.arst_n    (arst_n),
		.degree    (cfg_q.degree),
		.in_valid  (loc_valid),
		.in_ready  (loc_ready),
		.loc       (loc),
		.out_valid (bas_valid),
		.out_ready (bas_ready),
		.basis     (bas)
	);

	ubsb_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.degree    (cfg_q.degree),
		.in_valid  (bas_valid),
		.in_ready  (bas_ready),
		.basis     (bas),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (out_index),
		.out_value (out_value),
		.out_last  (m_tlast),
		.out_oor   (out_oor)
	);

	assign m_tdata    = {out_value, out_index};
	assign m_tuser[0] = out_oor;

endmodule
